// ===== design/sd_spi_host_controller_macros.svh =====
// assertion macros for the sd spi host controller checker
// no dependencies
`ifndef SD_SPI_HOST_CONTROLLER_MACROS_SVH
`define SD_SPI_HOST_CONTROLLER_MACROS_SVH
// implication checked on every clock outside reset
`define SDH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdh check failed");
// implication whose consequent is checked on the following clock
`define SDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdh check failed");
`endif

// ===== design/sdh_pkg.sv =====
// types and constants for the sd spi host controller
// no dependencies
`timescale 1ns / 1ps
package sdh_pkg;
   typedef enum logic [3:0] {
      PH_IDLE, PH_DUMMY, PH_READY, PH_FRAME, PH_STUFF, PH_RESP, PH_OCR, PH_TOKEN,
      PH_RDATA, PH_RCRC, PH_WREADY, PH_WTOKEN, PH_WREQ, PH_WDATA, PH_WCRC, PH_WRESP
   } phase_type;
   typedef enum logic [3:0] {
      AT_CMD0, AT_CMD8, AT_A41V2, AT_CMD58, AT_A41V1F, AT_A41V1, AT_CMD16,
      AT_RD, AT_STOP, AT_A23, AT_WR
   } resume_type;
   localparam logic [2:0] CMD_INIT = 3'd0;
   localparam logic [2:0] CMD_READ = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_CARD = 3'd3;
   localparam logic [2:0] CMD_WBYTE = 3'd4;
   localparam logic [2:0] CMD_TICK = 3'd5;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;
   localparam logic [1:0] ST_BAD = 2'd3;
   localparam logic [1:0] CSR_TRIES = 2'd0;
   localparam logic [1:0] CSR_INIT_TO = 2'd1;
   localparam logic [1:0] CSR_READY_TO = 2'd2;
   localparam logic [1:0] CSR_TOKEN_TO = 2'd3;
   localparam logic [7:0] TOK_SINGLE = 8'hFE;
   localparam logic [7:0] TOK_MULTI = 8'hFC;
   localparam logic [7:0] TOK_STOP = 8'hFD;
   typedef struct packed {
      logic [7:0] tries;
      logic [15:0] init_to;
      logic [15:0] ready_to;
      logic [15:0] token_to;
   } cfg_type;
   typedef struct packed {
      logic send_valid;
      logic [7:0] send_byte;
      logic cs;
      logic slow;
      logic read_valid;
      logic [7:0] read_byte;
      logic write_request;
      logic done;
      logic [1:0] status;
      logic [7:0] blocks_left;
      logic [1:0] card_type;
   } result_type;
endpackage

// ===== design/sdh_csr.sv =====
// configuration registers of the sd spi host controller
// depends on sdh_pkg
`timescale 1ns / 1ps
module sdh_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   output sdh_pkg::cfg_type cfg
);
   import sdh_pkg::*;
   cfg_type cfg_ff, cfg_in;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIES: cfg_in.tries = csr_data[7:0];
            CSR_INIT_TO: cfg_in.init_to = csr_data;
            CSR_READY_TO: cfg_in.ready_to = csr_data;
            CSR_TOKEN_TO: cfg_in.token_to = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tries: 8'd10, init_to: 16'd1000, ready_to: 16'd500, token_to: 16'd100};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
   assign cfg = cfg_ff;
endmodule

// ===== design/sdh_engine.sv =====
// protocol sequencer: one word in, next state and one result out
// depends on sdh_pkg
`timescale 1ns / 1ps
module sdh_engine (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [2:0] command,
   input  logic [31:0] sector,
   input  logic [7:0] block_count,
   input  logic [7:0] card_byte,
   input  logic [7:0] write_byte,
   input  sdh_pkg::cfg_type cfg,
   output sdh_pkg::result_type res
);
   import sdh_pkg::*;
   phase_type phase_ff, phase_in;
   resume_type resume_ff, resume_in;
   logic [1:0] type_ff, type_in;
   logic [9:0] cnt_ff, cnt_in;
   logic [7:0] tries_ff, tries_in;
   logic [15:0] to_ff, to_in, init_ff, init_in;
   logic [5:0] idx_ff, idx_in;
   logic [31:0] arg_ff, arg_in, ocr_ff, ocr_in, addr_ff, addr_in;
   logic [7:0] blocks_ff, blocks_in, tok_ff, tok_in;
   logic app_ff, app_in, multi_ff, multi_in, cs_ff, cs_in, slow_ff, slow_in;
   logic job_init_ff, job_init_in;
   logic [1:0] fail_ff, fail_in;
   result_type r;

   function automatic logic [1:0] rcode(input logic [7:0] v);
      rcode = v[7] ? ST_TIMEOUT : ST_REJECT;
   endfunction

   always_comb begin
      logic [7:0] rv;
      logic [5:0] fi;
      logic [31:0] fa;
      logic [1:0] fc;
      logic do_deliver, do_finish, do_issue, do_wblk, do_wfail, do_readend, do_token;
      logic do_ifail, do_v1, do_v2, iss_app;
      logic [5:0] iss_idx;
      logic [31:0] iss_arg;
      resume_type iss_at;
      logic [7:0] wtok;
      logic [1:0] ifail_c, wfail_c;
      logic [9:0] cn;
      logic [31:0] ocr_n;
      phase_in = phase_ff; resume_in = resume_ff; type_in = type_ff; cnt_in = cnt_ff;
      tries_in = tries_ff; to_in = to_ff; init_in = init_ff; idx_in = idx_ff;
      arg_in = arg_ff; ocr_in = ocr_ff; addr_in = addr_ff; blocks_in = blocks_ff;
      tok_in = tok_ff; app_in = app_ff; multi_in = multi_ff; cs_in = cs_ff;
      slow_in = slow_ff; job_init_in = job_init_ff; fail_in = fail_ff;
      r = '0;
      rv = 8'hFF; do_deliver = 1'b0; do_finish = 1'b0; do_issue = 1'b0;
      do_wblk = 1'b0; do_wfail = 1'b0; do_readend = 1'b0; do_token = 1'b0;
      do_ifail = 1'b0; do_v1 = 1'b0; do_v2 = 1'b0; iss_app = 1'b0;
      iss_idx = '0; iss_arg = '0; iss_at = AT_CMD0; wtok = TOK_SINGLE;
      ifail_c = ST_OK; wfail_c = ST_OK;
      cn = cnt_ff + 10'd1;
      ocr_n = {ocr_ff[23:0], card_byte};
      // command frame byte for the current counter
      fi = app_ff ? 6'd55 : idx_ff;
      fa = app_ff ? 32'd0 : arg_ff;
      case (cnt_ff[2:0])
         3'd0: fc = 2'd0;
         default: fc = 2'd0;
      endcase
      case (command)
         CMD_INIT: begin
            if (phase_ff == PH_IDLE) begin
               job_init_in = 1'b1; fail_in = ST_OK; type_in = 2'd0; slow_in = 1'b1;
               cs_in = 1'b0; cnt_in = '0; phase_in = PH_DUMMY;
               r.send_valid = 1'b1; r.send_byte = 8'hFF;
            end
         end
         CMD_READ, CMD_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               job_init_in = 1'b0; fail_in = ST_OK; blocks_in = block_count;
               if (block_count == 8'd0) begin
                  do_finish = 1'b1;
               end else begin
                  multi_in = block_count != 8'd1;
                  addr_in = (type_ff == 2'd3) ? sector : {sector[22:0], 9'd0};
                  do_issue = 1'b1; iss_arg = addr_in;
                  if (command == CMD_READ) begin
                     iss_idx = multi_in ? 6'd18 : 6'd17; iss_at = AT_RD;
                  end else if (!multi_in) begin
                     iss_idx = 6'd24; iss_at = AT_WR;
                  end else if (type_ff != 2'd0) begin
                     iss_idx = 6'd23; iss_arg = {24'd0, block_count}; iss_app = 1'b1;
                     iss_at = AT_A23;
                  end else begin
                     iss_idx = 6'd25; iss_at = AT_WR;
                  end
               end
            end
         end
         CMD_CARD: begin
            case (phase_ff)
               PH_DUMMY: begin
                  cnt_in = cn;
                  if (cn < 10'd10) begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     do_issue = 1'b1; iss_idx = 6'd0; iss_at = AT_CMD0;
                  end
               end
               PH_READY: begin
                  if (card_byte == 8'hFF) begin
                     phase_in = PH_FRAME; cnt_in = '0;
                     r.send_valid = 1'b1; r.send_byte = {2'b01, fi};
                  end else if (to_ff == 16'd0) begin
                     cs_in = 1'b0; do_deliver = 1'b1; rv = 8'hFF;
                  end else begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end
               end
               PH_FRAME: begin
                  cnt_in = cn;
                  r.send_valid = 1'b1;
                  if (cn < 10'd6) begin
                     case (cn[2:0])
                        3'd1: r.send_byte = fa[31:24];
                        3'd2: r.send_byte = fa[23:16];
                        3'd3: r.send_byte = fa[15:8];
                        3'd4: r.send_byte = fa[7:0];
                        default: r.send_byte = (fi == 6'd0) ? 8'h95 :
                                               (fi == 6'd8) ? 8'h87 : 8'h01;
                     endcase
                  end else begin
                     tries_in = (cfg.tries != 8'd0) ? cfg.tries : 8'd1;
                     phase_in = (!app_ff && idx_ff == 6'd12) ? PH_STUFF : PH_RESP;
                     r.send_byte = 8'hFF;
                  end
               end
               PH_STUFF: begin
                  phase_in = PH_RESP; r.send_valid = 1'b1; r.send_byte = 8'hFF;
               end
               PH_RESP: begin
                  if (card_byte[7] && tries_ff > 8'd1) begin
                     tries_in = tries_ff - 8'd1; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     do_deliver = 1'b1; rv = card_byte;
                  end
               end
               PH_OCR: begin
                  ocr_in = ocr_n; cnt_in = cn;
                  if (cn < 10'd4) begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else if (resume_ff == AT_CMD8) begin
                     if (ocr_n[15:8] == 8'h01 && ocr_n[7:0] == 8'hAA) do_v2 = 1'b1;
                     else begin
                        do_ifail = 1'b1; ifail_c = ST_REJECT;
                     end
                  end else begin
                     type_in = ocr_n[30] ? 2'd3 : 2'd2; do_finish = 1'b1;
                  end
               end
               PH_TOKEN: begin
                  if (card_byte == 8'hFF && to_ff != 16'd0) begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else if (card_byte == TOK_SINGLE) begin
                     phase_in = PH_RDATA; cnt_in = '0;
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     if (fail_ff == ST_OK)
                        fail_in = (card_byte == 8'hFF) ? ST_TIMEOUT : ST_BAD;
                     do_readend = 1'b1;
                  end
               end
               PH_RDATA: begin
                  r.read_valid = 1'b1; r.read_byte = card_byte;
                  cnt_in = cn;
                  if (cn[9]) begin
                     phase_in = PH_RCRC; cnt_in = '0;
                  end
                  r.send_valid = 1'b1; r.send_byte = 8'hFF;
               end
               PH_RCRC: begin
                  cnt_in = cn;
                  if (cn < 10'd2) begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     blocks_in = blocks_ff - 8'd1;
                     if (multi_ff && blocks_in != 8'd0) do_token = 1'b1;
                     else do_readend = 1'b1;
                  end
               end
               PH_WREADY: begin
                  if (card_byte == 8'hFF) begin
                     phase_in = PH_WTOKEN; r.send_valid = 1'b1; r.send_byte = tok_ff;
                  end else if (to_ff == 16'd0) begin
                     do_wfail = 1'b1; wfail_c = ST_TIMEOUT;
                  end else begin
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end
               end
               PH_WTOKEN: begin
                  if (tok_ff == TOK_STOP) do_finish = 1'b1;
                  else begin
                     cnt_in = '0; phase_in = PH_WREQ; r.write_request = 1'b1;
                  end
               end
               PH_WDATA: begin
                  cnt_in = cn;
                  if (!cn[9]) begin
                     phase_in = PH_WREQ; r.write_request = 1'b1;
                  end else begin
                     phase_in = PH_WCRC; cnt_in = '0;
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end
               end
               PH_WCRC: begin
                  cnt_in = cn;
                  if (cn >= 10'd2) phase_in = PH_WRESP;
                  r.send_valid = 1'b1; r.send_byte = 8'hFF;
               end
               PH_WRESP: begin
                  if (card_byte[4:0] == 5'h05) begin
                     if (tok_ff == TOK_SINGLE) begin
                        blocks_in = '0; do_finish = 1'b1;
                     end else begin
                        blocks_in = blocks_ff - 8'd1; do_wblk = 1'b1;
                        wtok = (blocks_in != 8'd0) ? TOK_MULTI : TOK_STOP;
                     end
                  end else begin
                     do_wfail = 1'b1; wfail_c = ST_BAD;
                  end
               end
               default: ;
            endcase
         end
         CMD_WBYTE: begin
            if (phase_ff == PH_WREQ) begin
               r.send_valid = 1'b1; r.send_byte = write_byte; phase_in = PH_WDATA;
            end
         end
         CMD_TICK: begin
            if (to_ff != 16'd0) to_in = to_ff - 16'd1;
            if (init_ff != 16'd0) init_in = init_ff - 16'd1;
         end
         default: ;
      endcase

      // response delivery, app prefix first
      if (do_deliver) begin
         app_in = 1'b0;
         if (app_ff && rv <= 8'd1) begin
            cs_in = 1'b1; to_in = cfg.ready_to; phase_in = PH_READY;
            r.send_valid = 1'b1; r.send_byte = 8'hFF;
         end else begin
            case (resume_ff)
               AT_CMD0: begin
                  if (rv == 8'd1) begin
                     init_in = cfg.init_to; do_issue = 1'b1; iss_idx = 6'd8;
                     iss_arg = 32'h1AA; iss_at = AT_CMD8;
                  end else begin
                     do_ifail = 1'b1; ifail_c = rcode(rv);
                  end
               end
               AT_CMD8: begin
                  if (rv == 8'd1) begin
                     phase_in = PH_OCR; cnt_in = '0; ocr_in = '0;
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     do_issue = 1'b1; iss_idx = 6'd41; iss_app = 1'b1; iss_at = AT_A41V1F;
                  end
               end
               AT_A41V2: begin
                  if (rv != 8'd0) do_v2 = 1'b1;
                  else if (init_ff == 16'd0) begin
                     do_ifail = 1'b1; ifail_c = ST_TIMEOUT;
                  end else begin
                     do_issue = 1'b1; iss_idx = 6'd58; iss_at = AT_CMD58;
                  end
               end
               AT_CMD58: begin
                  if (rv == 8'd0) begin
                     phase_in = PH_OCR; cnt_in = '0; ocr_in = '0;
                     r.send_valid = 1'b1; r.send_byte = 8'hFF;
                  end else begin
                     do_ifail = 1'b1; ifail_c = rcode(rv);
                  end
               end
               AT_A41V1F: begin
                  if (rv <= 8'd1) begin
                     type_in = 2'd1; do_v1 = 1'b1;
                  end else begin
                     do_ifail = 1'b1; ifail_c = rcode(rv);
                  end
               end
               AT_A41V1: begin
                  if (rv != 8'd0) do_v1 = 1'b1;
                  else if (init_ff == 16'd0) begin
                     do_ifail = 1'b1; ifail_c = ST_TIMEOUT;
                  end else begin
                     do_issue = 1'b1; iss_idx = 6'd16; iss_arg = 32'd512; iss_at = AT_CMD16;
                  end
               end
               AT_CMD16: begin
                  if (rv != 8'd0) begin
                     do_ifail = 1'b1; ifail_c = rcode(rv);
                  end else do_finish = 1'b1;
               end
               AT_RD: begin
                  if (rv != 8'd0) begin
                     if (fail_ff == ST_OK) fail_in = rcode(rv);
                     do_finish = 1'b1;
                  end else do_token = 1'b1;
               end
               AT_A23: begin
                  do_issue = 1'b1; iss_idx = 6'd25; iss_arg = addr_ff; iss_at = AT_WR;
               end
               AT_WR: begin
                  if (rv != 8'd0) begin
                     if (fail_ff == ST_OK) fail_in = rcode(rv);
                     do_finish = 1'b1;
                  end else begin
                     do_wblk = 1'b1; wtok = multi_ff ? TOK_MULTI : TOK_SINGLE;
                  end
               end
               default: do_finish = 1'b1;
            endcase
         end
      end

      // init loop steps check the init timer first
      if (do_v2 || do_v1) begin
         if (init_ff == 16'd0) begin
            do_ifail = 1'b1; ifail_c = ST_TIMEOUT;
         end else begin
            do_issue = 1'b1; iss_idx = 6'd41; iss_app = 1'b1;
            iss_arg = do_v2 ? 32'h4000_0000 : 32'd0;
            iss_at = do_v2 ? AT_A41V2 : AT_A41V1;
         end
      end
      if (do_readend) begin
         if (multi_ff) begin
            do_issue = 1'b1; iss_idx = 6'd12; iss_arg = '0; iss_at = AT_STOP;
         end else do_finish = 1'b1;
      end
      if (do_wfail) begin
         if (fail_ff == ST_OK) fail_in = wfail_c;
         if (tok_ff == TOK_SINGLE) do_finish = 1'b1;
         else if (tok_ff == TOK_MULTI) begin
            do_wblk = 1'b1; wtok = TOK_STOP;
         end else begin
            blocks_in = 8'd1; do_finish = 1'b1;
         end
      end
      if (do_ifail) begin
         if (fail_ff == ST_OK) fail_in = ifail_c;
         type_in = 2'd0; do_finish = 1'b1;
      end
      if (do_token) begin
         to_in = cfg.token_to; phase_in = PH_TOKEN;
         r.send_valid = 1'b1; r.send_byte = 8'hFF;
      end
      if (do_wblk) begin
         tok_in = wtok; to_in = cfg.ready_to; phase_in = PH_WREADY;
         r.send_valid = 1'b1; r.send_byte = 8'hFF;
      end
      if (do_issue) begin
         idx_in = iss_idx; arg_in = iss_arg; app_in = iss_app; resume_in = iss_at;
         cs_in = 1'b1; to_in = cfg.ready_to; phase_in = PH_READY;
         r.send_valid = 1'b1; r.send_byte = 8'hFF;
      end
      if (do_finish) begin
         cs_in = 1'b0; phase_in = PH_IDLE; r.done = 1'b1;
         if (job_init_in) begin
            slow_in = 1'b0;
            r.status = (type_in != 2'd0) ? ST_OK : ((fail_in != ST_OK) ? fail_in : ST_REJECT);
            r.blocks_left = '0;
         end else begin
            r.status = (blocks_in == 8'd0) ? ST_OK :
                       ((fail_in != ST_OK) ? fail_in : ST_REJECT);
            r.blocks_left = blocks_in;
         end
      end
      r.cs = cs_in; r.slow = slow_in; r.card_type = type_in;
      r.send_byte = r.send_byte | {6'd0, fc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; resume_ff <= AT_CMD0; type_ff <= '0; cnt_ff <= '0;
         tries_ff <= '0; to_ff <= '0; init_ff <= '0; idx_ff <= '0; arg_ff <= '0;
         ocr_ff <= '0; addr_ff <= '0; blocks_ff <= '0; tok_ff <= '0; app_ff <= 1'b0;
         multi_ff <= 1'b0; cs_ff <= 1'b0; slow_ff <= 1'b1; job_init_ff <= 1'b1;
         fail_ff <= ST_OK;
      end else if (step) begin
         phase_ff <= phase_in; resume_ff <= resume_in; type_ff <= type_in;
         cnt_ff <= cnt_in; tries_ff <= tries_in; to_ff <= to_in; init_ff <= init_in;
         idx_ff <= idx_in; arg_ff <= arg_in; ocr_ff <= ocr_in; addr_ff <= addr_in;
         blocks_ff <= blocks_in; tok_ff <= tok_in; app_ff <= app_in;
         multi_ff <= multi_in; cs_ff <= cs_in; slow_ff <= slow_in;
         job_init_ff <= job_init_in; fail_ff <= fail_in;
      end
   end
   assign res = r;
endmodule

// ===== design/sd_spi_host_controller.sv =====
// Each request word (init, read, write, card byte, write byte, tick) is taken when
// req_valid and req_ready are high; its result word is registered in the two-entry
// output buffer (out_ff, or skid_ff while stalled). Words stream back to back at
// one per cycle while rsp_ready is high; req_ready depends only on buffer occupancy.
// Configuration writes should be made only while the block is idle.
// top level, depends on sdh_pkg, sdh_csr and sdh_engine
`timescale 1ns / 1ps
module sd_spi_host_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_command,
   input  logic [31:0] req_sector,
   input  logic [7:0] req_block_count,
   input  logic [7:0] req_card_byte,
   input  logic [7:0] req_write_byte,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_spi_send_valid,
   output logic [7:0] rsp_spi_send_byte,
   output logic rsp_chip_select,
   output logic rsp_spi_slow,
   output logic rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic rsp_write_request,
   output logic rsp_done_res,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_blocks_left,
   output logic [1:0] rsp_card_type
);
   import sdh_pkg::*;
   cfg_type cfg;
   result_type eng_res, out_ff, out_in, skid_ff, skid_in;
   logic ov_ff, ov_in, sv_ff, sv_in, step;

   assign csr_ready = 1'b1;
   assign req_ready = !sv_ff;
   assign step = req_valid && req_ready;

   sdh_csr u_csr (.clock, .reset, .csr_valid, .csr_index, .csr_data, .cfg);
   sdh_engine u_eng (.clock, .reset, .step, .command(req_command), .sector(req_sector),
      .block_count(req_block_count), .card_byte(req_card_byte),
      .write_byte(req_write_byte), .cfg, .res(eng_res));

   always_comb begin
      ov_in = ov_ff; sv_in = sv_ff; out_in = out_ff; skid_in = skid_ff;
      if (!ov_ff || rsp_ready) begin
         if (sv_ff) begin
            out_in = skid_ff; ov_in = 1'b1; sv_in = 1'b0;
         end else begin
            out_in = eng_res; ov_in = step;
         end
      end else if (step) begin
         skid_in = eng_res; sv_in = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; sv_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in; sv_ff <= sv_in;
      end
      out_ff <= out_in; skid_ff <= skid_in;
   end
   assign rsp_valid = ov_ff;
   assign rsp_spi_send_valid = out_ff.send_valid;
   assign rsp_spi_send_byte = out_ff.send_byte;
   assign rsp_chip_select = out_ff.cs;
   assign rsp_spi_slow = out_ff.slow;
   assign rsp_read_valid = out_ff.read_valid;
   assign rsp_read_byte = out_ff.read_byte;
   assign rsp_write_request = out_ff.write_request;
   assign rsp_done_res = out_ff.done;
   assign rsp_status = out_ff.status;
   assign rsp_blocks_left = out_ff.blocks_left;
   assign rsp_card_type = out_ff.card_type;
endmodule

// ===== design/sdh_checker.sv =====
// port-level checks for the sd spi host controller, bound to the top level
// depends on sd_spi_host_controller_macros.svh
`timescale 1ns / 1ps
`include "sd_spi_host_controller_macros.svh"
module sdh_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_done_res,
   input logic rsp_chip_select,
   input logic rsp_read_valid,
   input logic rsp_write_request,
   input logic rsp_spi_send_valid
);
   `SDH_ASSERT_IMP(a_done_deselects, clock, reset, rsp_valid && rsp_done_res, !rsp_chip_select)
   `SDH_ASSERT_IMP(a_read_sends, clock, reset, rsp_valid && rsp_read_valid, rsp_spi_send_valid)
   `SDH_ASSERT_IMP(a_wreq_alone, clock, reset, rsp_valid && rsp_write_request, !rsp_spi_send_valid && !rsp_done_res)
   `SDH_ASSERT_NEXT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind sd_spi_host_controller sdh_checker u_sdh_checker (.clock, .reset, .rsp_valid,
   .rsp_ready, .rsp_done_res, .rsp_chip_select, .rsp_read_valid, .rsp_write_request,
   .rsp_spi_send_valid);
